// ===== rtl/lbsf_pkg.sv =====
package lbsf_pkg;

	localparam int PATTERN_CHARS = 8;
	localparam int WIN_DEPTH     = PATTERN_CHARS - 1;
	localparam int CHAR_W        = 8;
	localparam int LINE_W        = 10;
	localparam int POS_W         = 8;
	localparam int LEN_W         = 4;
	localparam int PAT_W         = PATTERN_CHARS * CHAR_W;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_CHARS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd1;

	localparam logic CMD_BEGIN = 1'b0;
	localparam logic CMD_CHAR  = 1'b1;

	typedef struct packed {
		logic shift;
		logic clear;
	} win_ctrl_t;

endpackage

// ===== rtl/lbsf_cell.sv =====
module lbsf_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lbsf_pkg::win_ctrl_t        ctrl,
	input  logic [lbsf_pkg::CHAR_W-1:0] byte_in,
	input  logic                       valid_in,
	input  logic [lbsf_pkg::CHAR_W-1:0] exp_byte,
	input  logic                       cmp_en,
	output logic [lbsf_pkg::CHAR_W-1:0] byte_q,
	output logic                       valid_q,
	output logic                       hit
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			byte_q <= byte_in;
		end
	end

	// a lane outside the pattern always agrees
	assign hit = !cmp_en || (valid_q && (byte_q == exp_byte));

endmodule

// ===== rtl/line_bounded_substring_find_core.sv =====
// channel | handshake            | payload
// cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
// in      | in_valid/in_ready    | command, char_in, line_index, char_pos, end_of_line, end_of_scan
// out     | out_valid/out_ready  | found, match_line, match_pos
// one character per cycle unless a result waits; the compare across the cell row and the window shift
// happen in the cycle a transaction is taken, the result is registered and shows in the next cycle
// a single output register; input stalls only while a result waits unclaimed
// reset empties the window and arms the search; pattern registers reset to zero
module line_bounded_substring_find_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lbsf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lbsf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            command,
	input  logic [lbsf_pkg::CHAR_W-1:0]     char_in,
	input  logic [lbsf_pkg::LINE_W-1:0]     line_index,
	input  logic [lbsf_pkg::POS_W-1:0]      char_pos,
	input  logic                            end_of_line,
	input  logic                            end_of_scan,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            found,
	output logic [lbsf_pkg::LINE_W-1:0]     match_line,
	output logic [lbsf_pkg::POS_W-1:0]      match_pos
);

	logic [lbsf_pkg::PAT_W-1:0]  pattern_q;
	logic [lbsf_pkg::LEN_W-1:0]  pat_len_q;
	logic [lbsf_pkg::LEN_W-1:0]  len_eff;
	logic [lbsf_pkg::LEN_W-1:0]  len_m1;
	logic [lbsf_pkg::CHAR_W-1:0] lane_exp [lbsf_pkg::PATTERN_CHARS];
	logic [lbsf_pkg::PATTERN_CHARS-1:0] lane_en;
	logic [lbsf_pkg::CHAR_W-1:0] win_byte  [lbsf_pkg::WIN_DEPTH];
	logic [lbsf_pkg::WIN_DEPTH-1:0] win_valid;
	logic [lbsf_pkg::WIN_DEPTH-1:0] win_hit;
	logic                        done_q;
	logic                        take;
	logic                        is_char;
	logic                        active;
	logic                        match;
	logic                        emit;
	logic [lbsf_pkg::POS_W-1:0]  start_pos;
	lbsf_pkg::win_ctrl_t         ctrl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			pat_len_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == lbsf_pkg::CFG_PATTERN_CHARS) begin
				pattern_q <= cfg_data[lbsf_pkg::PAT_W-1:0];
			end else if (cfg_index == lbsf_pkg::CFG_PATTERN_LENGTH) begin
				pat_len_q <= cfg_data[lbsf_pkg::LEN_W-1:0];
			end
		end
	end

	assign len_eff = (pat_len_q > lbsf_pkg::LEN_W'(lbsf_pkg::PATTERN_CHARS))
		? lbsf_pkg::LEN_W'(lbsf_pkg::PATTERN_CHARS) : pat_len_q;
	assign len_m1 = len_eff - lbsf_pkg::LEN_W'(1);

	// lane j holds the pattern byte that must sit j characters back
	always_comb begin
		logic [lbsf_pkg::LEN_W-1:0] idx;
		for (int j = 0; j < lbsf_pkg::PATTERN_CHARS; j++) begin
			idx         = len_m1 - lbsf_pkg::LEN_W'(j);
			lane_exp[j] = pattern_q[idx[2:0]*lbsf_pkg::CHAR_W +: lbsf_pkg::CHAR_W];
			lane_en[j]  = lbsf_pkg::LEN_W'(j) < len_eff;
		end
	end

	for (genvar k = 0; k < lbsf_pkg::WIN_DEPTH; k++) begin : g_cell
		logic [lbsf_pkg::CHAR_W-1:0] b_in;
		logic                        v_in;
		if (k == 0) begin : g_head
			assign b_in = char_in;
			assign v_in = 1'b1;
		end else begin : g_link
			assign b_in = win_byte[k-1];
			assign v_in = win_valid[k-1];
		end
		lbsf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.byte_in  (b_in),
			.valid_in (v_in),
			.exp_byte (lane_exp[k+1]),
			.cmp_en   (lane_en[k+1]),
			.byte_q   (win_byte[k]),
			.valid_q  (win_valid[k]),
			.hit      (win_hit[k])
		);
	end

	assign in_ready = !out_valid || out_ready;
	assign take     = in_valid && in_ready;
	assign is_char  = command == lbsf_pkg::CMD_CHAR;
	assign active   = is_char && !done_q;
	// lane zero is enabled only for a non-empty pattern
	assign match    = lane_en[0] && (char_in == lane_exp[0]) && (&win_hit);
	assign emit     = take && active && (match || end_of_scan);

	assign ctrl.clear = take && (!is_char || (active && !match && end_of_line));
	assign ctrl.shift = take && active && !match && !end_of_line;

	assign start_pos = (char_pos >= lbsf_pkg::POS_W'(len_m1))
		? char_pos - lbsf_pkg::POS_W'(len_m1) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (take) begin
			if (!is_char) begin
				done_q <= 1'b0;
			end else if (emit) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			found      <= match;
			match_line <= match ? line_index : '0;
			match_pos  <= match ? start_pos : '0;
		end
	end

endmodule

// ===== rtl/lbsf_checker.sv =====
module lbsf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            command,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            found,
	input logic [lbsf_pkg::LINE_W-1:0]     match_line,
	input logic [lbsf_pkg::POS_W-1:0]      match_pos
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found)
			&& $stable(match_line) && $stable(match_pos))
		else $error("result changed while stalled");

	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_line == '0 && match_pos == '0)
		else $error("not found result carries a position");

	a_caused: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && command == lbsf_pkg::CMD_CHAR))
		else $error("result without a character transaction");

endmodule

bind line_bounded_substring_find_core lbsf_checker u_lbsf_checker (.*);

// ===== sim/tb_line_bounded_substring_find_core.sv =====
`timescale 1ns / 1ps

module tb_line_bounded_substring_find_core;

	import lbsf_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TARGET_CHARS = 400;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_PATTERN_LENGTH + 1'b1;

	typedef struct packed {
		logic              found;
		logic [LINE_W-1:0] line;
		logic [POS_W-1:0]  pos;
	} search_result_t;

	typedef struct packed {
		logic              command;
		logic [CHAR_W-1:0] ch;
		logic [LINE_W-1:0] line;
		logic [POS_W-1:0]  pos;
		logic              eol;
		logic              eos;
	} text_item_t;

	typedef struct {
		bit                    is_write;
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] reg_data;
		text_item_t            item;
		bit                    fixed;
		bit                    fixed_has;
		search_result_t        fixed_res;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  command = CMD_BEGIN;
	logic [CHAR_W-1:0]     char_in = '0;
	logic [LINE_W-1:0]     line_index = '0;
	logic [POS_W-1:0]      char_pos = '0;
	logic                  end_of_line = 1'b0;
	logic                  end_of_scan = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  found;
	logic [LINE_W-1:0]     match_line;
	logic [POS_W-1:0]      match_pos;

	line_bounded_substring_find_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.char_in     (char_in),
		.line_index  (line_index),
		.char_pos    (char_pos),
		.end_of_line (end_of_line),
		.end_of_scan (end_of_scan),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.match_line  (match_line),
		.match_pos   (match_pos)
	);

	// search model state
	logic [CHAR_W-1:0] recent_chars [WIN_DEPTH];
	int unsigned       recent_fill = 0;
	bit                scan_closed = 1'b0;
	logic [PAT_W-1:0]  pat_reg = '0;
	logic [LEN_W-1:0]  len_reg = '0;

	search_result_t awaited_results [$];
	plan_row_t      plan [$];

	bit stalls_on = 1'b1;
	int mismatches = 0;
	int sent_items = 0;
	int live_items = 0;
	int hits = 0;
	int misses = 0;
	int phases = 0;
	int cycle_count = 0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				awaited_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk)
		out_ready <= !stalls_on || ($urandom_range(0, 99) >= 9);

	task automatic report_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		$display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
		mismatches++;
	endtask

	always @(posedge clk) begin
		search_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected result", 32'h0,
					32'({found, match_line, match_pos}));
			end else begin
				want = awaited_results.pop_front();
				if (found !== want.found)
					report_mismatch("found", 32'(want.found), 32'(found));
				if (match_line !== want.line)
					report_mismatch("match_line", 32'(want.line), 32'(match_line));
				if (match_pos !== want.pos)
					report_mismatch("match_pos", 32'(want.pos), 32'(match_pos));
				if (want.found)
					hits++;
				else
					misses++;
			end
		end
	end

	function automatic void clear_window();
		foreach (recent_chars[k])
			recent_chars[k] = '0;
		recent_fill = 0;
	endfunction

	function automatic int unsigned active_length();
		return (len_reg > PATTERN_CHARS) ? PATTERN_CHARS : len_reg;
	endfunction

	// one text transaction through the search; returns 1 when it yields a result
	function automatic bit match_step(input text_item_t it, output search_result_t res);
		int unsigned n;
		bit hit;
		res = '0;
		hit = 1'b0;
		if (it.command == CMD_BEGIN) begin
			clear_window();
			scan_closed = 1'b0;
			return 1'b0;
		end
		if (scan_closed)
			return 1'b0;
		n = active_length();
		if (n != 0 && recent_fill >= n - 1 && pat_reg[(n-1)*CHAR_W +: CHAR_W] == it.ch) begin
			hit = 1'b1;
			for (int k = 1; k < n; k++)
				if (pat_reg[(n-1-k)*CHAR_W +: CHAR_W] != recent_chars[k-1])
					hit = 1'b0;
		end
		if (hit) begin
			scan_closed = 1'b1;
			res.found = 1'b1;
			res.line = it.line;
			// column before the match length means the host sent odd positions
			res.pos = (it.pos >= n - 1) ? POS_W'(it.pos - (n - 1)) : '0;
			return 1'b1;
		end
		if (it.eol) begin
			clear_window();
		end else begin
			for (int k = WIN_DEPTH - 1; k > 0; k--)
				recent_chars[k] = recent_chars[k-1];
			recent_chars[0] = it.ch;
			if (recent_fill < WIN_DEPTH)
				recent_fill++;
		end
		if (it.eos) begin
			scan_closed = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic send_item(input text_item_t it, input bit fixed, input bit fixed_has,
		input search_result_t fixed_res);
		search_result_t res;
		bit has;
		bit live;
		while (stalls_on && $urandom_range(0, 99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= it.command;
		char_in <= it.ch;
		line_index <= it.line;
		char_pos <= it.pos;
		end_of_line <= it.eol;
		end_of_scan <= it.eos;
		do @(posedge clk); while (!in_ready);
		live = (it.command == CMD_BEGIN) || !scan_closed;
		has = match_step(it, res);
		if (fixed) begin
			has = fixed_has;
			res = fixed_res;
		end
		if (has)
			awaited_results.push_back(res);
		if (live)
			live_items++;
		sent_items++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx == CFG_PATTERN_CHARS)
			pat_reg = data;
		else if (idx == CFG_PATTERN_LENGTH)
			len_reg = data[LEN_W-1:0];
	endtask

	// block must be idle before a register write
	task automatic settle();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	function automatic text_item_t random_item();
		logic [31:0] r;
		r = $urandom;
		return r[$bits(text_item_t)-1:0];
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		plan_row_t row;
		row = '{default: '0};
		row.is_write = 1'b1;
		row.reg_index = idx;
		row.reg_data = data;
		plan.push_back(row);
	endfunction

	function automatic void add_char(input logic cmd, input logic [CHAR_W-1:0] ch,
		input logic [LINE_W-1:0] ln, input logic [POS_W-1:0] p, input logic eol, input logic eos);
		plan_row_t row;
		row = '{default: '0};
		row.item = '{command: cmd, ch: ch, line: ln, pos: p, eol: eol, eos: eos};
		plan.push_back(row);
	endfunction

	function automatic void fix_last(input bit has, input logic f, input logic [LINE_W-1:0] ln,
		input logic [POS_W-1:0] p);
		plan[plan.size()-1].fixed = 1'b1;
		plan[plan.size()-1].fixed_has = has;
		plan[plan.size()-1].fixed_res = '{found: f, line: ln, pos: p};
	endfunction

	task automatic random_settings();
		logic [CFG_DATA_W-1:0] d;
		int unsigned sel;
		int unsigned pick;
		int unsigned n;
		sel = $urandom_range(0, 19);
		pick = $urandom_range(0, 19);
		if (pick == 0)
			n = 0;
		else if (pick <= 2)
			n = $urandom_range(9, 15);
		else if (pick == 3)
			n = PATTERN_CHARS;
		else if (pick == 4)
			n = $urandom_range(5, 7);
		else
			n = $urandom_range(1, 4);
		d = {$urandom, $urandom};
		if (sel != 0)
			write_reg(CFG_PATTERN_CHARS, d);
		d = {$urandom, $urandom};
		d[LEN_W-1:0] = LEN_W'(n);
		if (sel != 1)
			write_reg(CFG_PATTERN_LENGTH, d);
		if (sel == 2)
			write_reg(CFG_UNMAPPED, {$urandom, $urandom});
		phases++;
	endtask

	// one search in host order: mostly a begin, then a few lines of text, with some noise
	task automatic run_search();
		int unsigned n_eff;
		int unsigned n_lines;
		int unsigned line_len;
		int unsigned embed;
		logic [LINE_W-1:0] ln;
		logic [POS_W-1:0] p0;
		bit drop_eos;
		text_item_t it;
		n_eff = active_length();
		if ($urandom_range(0, 9) != 0) begin
			it = random_item();
			it.command = CMD_BEGIN;
			send_item(it, 1'b0, 1'b0, '0);
		end
		n_lines = $urandom_range(1, 4);
		ln = LINE_W'($urandom_range(0, 1023));
		drop_eos = ($urandom_range(0, 9) == 0);
		for (int l = 0; l < n_lines; l++) begin
			line_len = $urandom_range(1, 12);
			p0 = ($urandom_range(0, 7) == 0) ? POS_W'($urandom_range(0, 255)) : '0;
			embed = n_eff;
			for (int j = 0; j < line_len; j++) begin
				if ($urandom_range(0, 29) == 0)
					send_item(random_item(), 1'b0, 1'b0, '0);
				if (embed >= n_eff && n_eff != 0 && $urandom_range(0, 5) == 0)
					embed = 0;
				it.command = CMD_CHAR;
				if (embed < n_eff) begin
					it.ch = pat_reg[embed*CHAR_W +: CHAR_W];
					embed++;
				end else if (n_eff != 0 && $urandom_range(0, 1) == 1) begin
					it.ch = pat_reg[$urandom_range(0, n_eff - 1)*CHAR_W +: CHAR_W];
				end else begin
					it.ch = CHAR_W'($urandom);
				end
				it.line = ln;
				it.pos = p0 + POS_W'(j);
				it.eol = (j == line_len - 1);
				it.eos = it.eol && (l == n_lines - 1) && !drop_eos;
				send_item(it, 1'b0, 1'b0, '0);
			end
			ln++;
		end
	endtask

	initial begin
		clear_window();

		// armed straight out of reset with an empty pattern
		add_char(CMD_CHAR, 8'h78, 10'd0, 8'd0, 1'b0, 1'b1);
		fix_last(1'b1, 1'b0, '0, '0);
		add_char(CMD_CHAR, 8'h79, 10'd1, 8'd1, 1'b0, 1'b1);
		fix_last(1'b0, 1'b0, '0, '0);
		add_char(CMD_BEGIN, 8'hFF, 10'h3FF, 8'hFF, 1'b1, 1'b1);
		fix_last(1'b0, 1'b0, '0, '0);
		// "ab": match on the line's last char, together with end of scan
		add_write(CFG_PATTERN_CHARS, 64'h6261);
		add_write(CFG_PATTERN_LENGTH, 64'd2);
		add_char(CMD_CHAR, 8'h61, 10'h3FF, 8'd254, 1'b0, 1'b0);
		add_char(CMD_CHAR, 8'h62, 10'h3FF, 8'd255, 1'b1, 1'b1);
		fix_last(1'b1, 1'b1, 10'h3FF, 8'd254);
		// same pattern split across a line end
		add_char(CMD_BEGIN, 8'h00, 10'd0, 8'd0, 1'b0, 1'b0);
		add_char(CMD_CHAR, 8'h61, 10'd5, 8'd7, 1'b1, 1'b0);
		add_char(CMD_CHAR, 8'h62, 10'd6, 8'd0, 1'b0, 1'b1);
		fix_last(1'b1, 1'b0, '0, '0);
		// length 15 saturates to a full eight-char pattern
		add_write(CFG_PATTERN_CHARS, '1);
		add_write(CFG_PATTERN_LENGTH, '1);
		add_char(CMD_BEGIN, 8'h00, 10'd0, 8'd0, 1'b0, 1'b0);
		for (int k = 0; k < PATTERN_CHARS; k++)
			add_char(CMD_CHAR, 8'hFF, 10'd3, POS_W'(k), 1'b0, 1'b0);
		fix_last(1'b1, 1'b1, 10'd3, 8'd0);
		// column too small for the match length
		add_write(CFG_PATTERN_LENGTH, 64'd2);
		add_char(CMD_BEGIN, 8'h00, 10'd0, 8'd0, 1'b0, 1'b0);
		add_char(CMD_CHAR, 8'hFF, 10'd9, 8'd0, 1'b0, 1'b0);
		add_char(CMD_CHAR, 8'hFF, 10'd9, 8'd0, 1'b0, 1'b0);
		fix_last(1'b1, 1'b1, 10'd9, 8'd0);
		// single zero byte pattern, plus a write to an unmapped index
		add_write(CFG_PATTERN_CHARS, '0);
		add_write(CFG_UNMAPPED, 64'hA5A5_5A5A_0F0F_F0F1);
		add_write(CFG_PATTERN_LENGTH, 64'd1);
		add_char(CMD_BEGIN, 8'h00, 10'd0, 8'd0, 1'b0, 1'b0);
		add_char(CMD_CHAR, 8'h00, 10'd512, 8'd128, 1'b0, 1'b0);
		fix_last(1'b1, 1'b1, 10'd512, 8'd128);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_write) begin
				settle();
				write_reg(plan[i].reg_index, plan[i].reg_data);
				phases++;
			end else begin
				send_item(plan[i].item, plan[i].fixed, plan[i].fixed_has, plan[i].fixed_res);
			end
		end

		while (sent_items < TARGET_CHARS) begin
			settle();
			random_settings();
			repeat ($urandom_range(1, 3)) begin
				// a quiet stretch with no stalls on either side
				stalls_on = !(sent_items >= 150 && sent_items < 230);
				run_search();
			end
		end
		stalls_on = 1'b1;

		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);

		$display("%0d text transactions sent (%0d while a search was open) across %0d register writes",
			sent_items, live_items, phases);
		$display("%0d matches and %0d scan-end misses compared", hits, misses);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/lbsf_pkg.sv
rtl/lbsf_cell.sv
rtl/line_bounded_substring_find_core.sv
rtl/lbsf_checker.sv
sim/tb_line_bounded_substring_find_core.sv
